// ===== rtl/tgcs_pkg.sv =====
// Shared types and constants for the text grid cursor and scroll block.
`default_nettype none
package tgcs_pkg;

    // Control bytes of the output stream
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_FG      = 2'd2;
    localparam logic [1:0] REG_BG      = 2'd3;

    // Register reset values
    localparam logic [7:0]  RST_COLUMNS = 8'd80;
    localparam logic [6:0]  RST_ROWS    = 7'd24;
    localparam logic [23:0] RST_FG      = 24'hC0C0C0;
    localparam logic [23:0] RST_BG      = 24'h000000;

    // One grid cell as stored in memory
    typedef struct packed {
        logic        reverse;
        logic        bold;
        logic [23:0] background;
        logic [23:0] foreground;
        logic [7:0]  code;
    } t_cell;

    localparam t_cell CELL_RESET = '{
        reverse:    1'b0,
        bold:       1'b0,
        background: RST_BG,
        foreground: RST_FG,
        code:       CH_SPACE
    };

    // Input item
    typedef struct packed {
        logic       mode;
        logic [7:0] byte_req;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_in;

    // Result item
    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [5:0]  cursor_row;
        logic        did_scroll;
        logic [7:0]  cell_code;
        logic [23:0] cell_foreground;
        logic [23:0] cell_background;
        logic        cell_bold;
        logic        cell_reverse;
    } t_out;

    // Default colors from the register file
    typedef struct packed {
        logic [23:0] foreground;
        logic [23:0] background;
    } t_colors;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/tgcs_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module tgcs_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tgcs_cfg.sv =====
// Configuration registers with clamped grid dimensions.
`default_nettype none
module tgcs_cfg
    import tgcs_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [23:0]                    i_cfg_data,
    output t_colors                             o_colors,
    output logic [$clog2(MAX_COLUMNS):0]        o_cols_eff,
    output logic [$clog2(MAX_LINES):0]          o_rows_eff
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_LINES);

    logic [7:0]  r_cols;
    logic [6:0]  r_rows;
    logic [23:0] r_fg;
    logic [23:0] r_bg;

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RST_COLUMNS;
            r_rows <= RST_ROWS;
            r_fg   <= RST_FG;
            r_bg   <= RST_BG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COLUMNS: r_cols <= i_cfg_data[7:0];
                REG_ROWS:    r_rows <= i_cfg_data[6:0];
                REG_FG:      r_fg   <= i_cfg_data;
                REG_BG:      r_bg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..max
    always_comb begin
        if (r_cols == 8'd0) begin
            o_cols_eff = (CW+1)'(1);
        end else if (9'(r_cols) > 9'(MAX_COLUMNS)) begin
            o_cols_eff = (CW+1)'(MAX_COLUMNS);
        end else begin
            o_cols_eff = (CW+1)'(r_cols);
        end
        if (r_rows == 7'd0) begin
            o_rows_eff = (RW+1)'(1);
        end else if (9'(r_rows) > 9'(MAX_LINES)) begin
            o_rows_eff = (RW+1)'(MAX_LINES);
        end else begin
            o_rows_eff = (RW+1)'(r_rows);
        end
    end

    assign o_colors = '{foreground: r_fg, background: r_bg};

endmodule
`default_nettype wire

// ===== rtl/text_grid_cursor_scroll.sv =====
// Text grid cursor and scroll engine: sequencer, cursor state and cell memory.
//
// Usage: the input channel (i_in_valid / o_in_ready, payload i_in) takes one
// item at a time. Mode 0 handles an output byte (CR, LF, BS, TAB or a
// character written at the cursor); mode 1 reads one cell of the active area.
// Every item yields exactly one result on the output channel (o_out_valid /
// i_out_ready, payload o_out) carrying the cursor after the item.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready and should be
// written only while the block is idle.
// A byte goes from idle to the done state; an in-area read passes a read
// state on the way for the registered memory read. A byte that scrolls
// passes a clear state that blanks all MAX_COLUMNS columns of the new bottom
// row, one column per cycle, through the single memory port. Scrolling itself rotates a row offset.
// Reset: after i_rst_n is released, the cell memory is swept to blank cells,
// all MAX_LINES * 2**clog2(MAX_COLUMNS) addresses, while no item is accepted;
// configuration writes are taken during the sweep.
// Stall: the result waits in an output register; one further item is taken
// and worked on meanwhile, and its result holds until the register frees.
`default_nettype none
module text_grid_cursor_scroll
    import tgcs_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_LINES);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_LINES * (2 ** CW);

    t_colors          colors;
    logic [CW:0]      cols_e;
    logic [RW:0]      rows_e;

    t_state           r_st;
    t_state           n_st;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [RW-1:0]    r_top;
    logic [AW-1:0]    r_init_addr;
    logic [CW-1:0]    r_clr_col;
    logic [RW-1:0]    r_clr_row;
    logic             r_scr;
    t_cell            r_cell;
    t_out             r_out;
    logic             r_out_valid;

    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    t_cell            ram_wdata;
    logic [$bits(t_cell)-1:0] ram_rdata;

    logic             acc;
    logic             out_free;
    logic             out_load;
    t_cell            blank;

    logic [CW:0]      col_inc;
    logic [CW:0]      tab_t;
    logic [CW:0]      cols_m1;
    logic [RW:0]      row_inc;
    logic [RW:0]      rows_m1;
    logic             in_area;
    logic             lf_scr;
    logic [RW-1:0]    lf_row;
    logic [RW-1:0]    bottom_rm;
    logic [RW-1:0]    bottom;
    logic [RW-1:0]    top_inc;
    logic [RW-1:0]    cur_phys;
    logic [RW-1:0]    rd_phys;
    logic             rd_in;

    logic [CW-1:0]    b_col;
    logic [RW-1:0]    b_row;
    logic             b_scr;
    logic             b_wr;

    // Map a logical row below MAX_LINES to its physical row
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] r);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= (RW+1)'(MAX_LINES)) begin
            phys_row = RW'(s - (RW+1)'(MAX_LINES));
        end else begin
            phys_row = RW'(s);
        end
    endfunction

    tgcs_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_colors    (colors),
        .o_cols_eff  (cols_e),
        .o_rows_eff  (rows_e)
    );

    tgcs_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign acc      = i_in_valid & o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign blank    = '{reverse: 1'b0, bold: 1'b0, background: colors.background,
                        foreground: colors.foreground, code: CH_SPACE};

    // Cursor arithmetic shared by the byte handlers, and read and clear row addressing
    always_comb begin
        col_inc   = {1'b0, r_col} + (CW+1)'(1);
        tab_t     = ({1'b0, r_col} + (CW+1)'(8)) & ~((CW+1)'(7));
        cols_m1   = cols_e - (CW+1)'(1);
        row_inc   = {1'b0, r_row} + (RW+1)'(1);
        rows_m1   = rows_e - (RW+1)'(1);
        in_area   = ({1'b0, r_col} < cols_e) && ({1'b0, r_row} < rows_e);
        lf_scr    = row_inc >= rows_e;
        lf_row    = lf_scr ? RW'(rows_m1) : RW'(row_inc);
        bottom_rm = (rows_e == (RW+1)'(MAX_LINES)) ? '0 : RW'(rows_e);
        bottom    = phys_row(r_top, bottom_rm);
        top_inc   = phys_row(r_top, RW'(1));
        cur_phys  = phys_row(r_top, r_row);
        rd_in     = (9'(i_in.read_row) < 9'(rows_e)) && (9'(i_in.read_col) < 9'(cols_e));
        rd_phys   = phys_row(r_top, RW'(i_in.read_row));
    end

    // Decode the output byte into the next cursor
    always_comb begin
        b_col = r_col;
        b_row = r_row;
        b_scr = 1'b0;
        b_wr  = 1'b0;
        unique case (i_in.byte_req)
            CH_CR: begin
                b_col = '0;
            end
            CH_LF: begin
                b_col = '0;
                b_row = lf_row;
                b_scr = lf_scr;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    b_col = r_col - CW'(1);
                end
            end
            CH_TAB: begin
                b_col = (tab_t < cols_e) ? CW'(tab_t) : CW'(cols_m1);
            end
            default: begin
                if (in_area) begin
                    b_wr = 1'b1;
                    if (col_inc >= cols_e) begin
                        b_col = '0;
                        b_row = lf_row;
                        b_scr = lf_scr;
                    end else begin
                        b_col = CW'(col_inc);
                    end
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_INIT: begin
                if (r_init_addr == AW'(DEPTH - 1)) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    if (i_in.mode) begin
                        n_st = rd_in ? ST_READ : ST_DONE;
                    end else begin
                        n_st = b_scr ? ST_CLEAR : ST_DONE;
                    end
                end
            end
            ST_READ: begin
                n_st = ST_DONE;
            end
            ST_CLEAR: begin
                if (r_clr_col == CW'(MAX_COLUMNS - 1)) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_INIT;
        endcase
    end

    // Memory port and handshake controls per state
    always_comb begin
        o_in_ready = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = {cur_phys, r_col};
        ram_wdata  = blank;
        out_load   = 1'b0;
        unique case (r_st)
            ST_INIT: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_init_addr;
                ram_wdata = CELL_RESET;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in.mode) begin
                    ram_en   = i_in_valid & rd_in;
                    ram_addr = {rd_phys, CW'(i_in.read_col)};
                end else begin
                    ram_en         = i_in_valid & b_wr;
                    ram_we         = 1'b1;
                    ram_wdata.code = i_in.byte_req;
                end
            end
            ST_READ: ;
            ST_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = {r_clr_row, r_clr_col};
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // Control state: sequencer, init sweep address, cursor, row offset, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_INIT) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (acc && !i_in.mode) begin
                r_col <= b_col;
                r_row <= b_row;
                if (b_scr) begin
                    r_top <= top_inc;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: row clear pointer, pending result, output register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_clr_row <= bottom;
            r_clr_col <= '0;
            r_scr     <= !i_in.mode && b_scr;
            r_cell    <= (i_in.mode && !rd_in) ? blank : '0;
        end
        if (r_st == ST_CLEAR) begin
            r_clr_col <= r_clr_col + CW'(1);
        end
        if (r_st == ST_READ) begin
            r_cell <= t_cell'(ram_rdata);
        end
        if (out_load) begin
            r_out.cursor_column   <= 7'(r_col);
            r_out.cursor_row      <= 6'(r_row);
            r_out.did_scroll      <= r_scr;
            r_out.cell_code       <= r_cell.code;
            r_out.cell_foreground <= r_cell.foreground;
            r_out.cell_background <= r_cell.background;
            r_out.cell_bold       <= r_cell.bold;
            r_out.cell_reverse    <= r_cell.reverse;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
